// ===== design/arq_pkg.sv =====
`timescale 1ns / 1ps

package arq_pkg;

   localparam int ID_COUNT = 64;
   localparam int IDX_W    = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
   localparam int ID_W     = 6;
   localparam int TIME_W   = 32;
   localparam int CNT_W    = 32;
   localparam int TMO_W    = 8;
   localparam int ACT_W    = 3;

   localparam logic [1:0] MODE_SEND = 2'd0;
   localparam logic [1:0] MODE_ACK  = 2'd1;
   localparam logic [1:0] MODE_RECV = 2'd2;
   localparam logic [1:0] MODE_TICK = 2'd3;

   localparam logic [ACT_W-1:0] ACT_TX      = 3'd0;
   localparam logic [ACT_W-1:0] ACT_RETX    = 3'd1;
   localparam logic [ACT_W-1:0] ACT_ACK     = 3'd2;
   localparam logic [ACT_W-1:0] ACT_DELIVER = 3'd3;
   localparam logic [ACT_W-1:0] ACT_FULL    = 3'd4;

   localparam logic [TMO_W-1:0] TIMEOUT_RESET = 8'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACK2,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   // One id's slot in the chain.
   typedef struct packed {
      logic              pending;
      logic              seen;
      logic [TIME_W-1:0] stamp;
   } entry_type;

   // Per-cell control from the sequencer.
   typedef struct packed {
      logic shift;
      logic set_pend;
      logic clr_pend;
      logic set_seen;
   } cell_cmd_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      sat_inc = (v == '1) ? v : v + CNT_W'(1);
   endfunction

endpackage

// ===== design/arq_cell.sv =====
`timescale 1ns / 1ps

module arq_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  arq_pkg::cell_cmd_type   cmd,
   input  logic [31:0]             stamp_in,
   input  arq_pkg::entry_type      from_next,
   output arq_pkg::entry_type      entry_out
);
   import arq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // Shift takes the neighbor's word; otherwise apply the local writes.
   always_comb begin
      entry_in = entry_ff;
      if (cmd.shift) begin
         entry_in = from_next;
      end else begin
         if (cmd.set_pend) begin
            entry_in.pending = 1'b1;
            entry_in.stamp   = stamp_in;
         end
         if (cmd.clr_pend) begin
            entry_in.pending = 1'b0;
         end
         if (cmd.set_seen) begin
            entry_in.seen = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.pending <= 1'b0;
         entry_ff.seen    <= 1'b0;
      end else begin
         entry_ff.pending <= entry_in.pending;
         entry_ff.seen    <= entry_in.seen;
      end
      entry_ff.stamp <= entry_in.stamp;
   end

   assign entry_out = entry_ff;

endmodule

// ===== design/arq_retransmit_tracker.sv =====
`timescale 1ns / 1ps

// Send and app message results are registered and show the cycle after accept; an ack
//   writes its cell and gives no result. Send and ack accept a new word every cycle; a
//   fresh app message gives a deliver, then an ack, and stays busy until the ack; a tick
//   stays busy while the ring rotates one entry past the head cell per cycle, then flushes.
// Reset (synchronous, active high) clears all pending and seen bits, the id and count.
// The receiver cannot stall: each result strobes rsp_valid for exactly one cycle.

module arq_retransmit_tracker (
   input  logic                        clock,
   input  logic                        reset,
   // request word
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_mode,
   input  logic [arq_pkg::ID_W-1:0]    req_msg_id,
   input  logic [arq_pkg::TIME_W-1:0]  req_now_seconds,
   // result word
   output logic                        rsp_valid,
   output logic [arq_pkg::ACT_W-1:0]   rsp_action,
   output logic [arq_pkg::ID_W-1:0]    rsp_out_id,
   output logic [arq_pkg::CNT_W-1:0]   rsp_transmissions,
   output logic                        rsp_last,
   // timeout register
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [arq_pkg::TMO_W-1:0]   csr_timeout_seconds
);
   import arq_pkg::*;

   state_type state_ff, state_in;

   logic [ID_W-1:0]   next_id_ff, next_id_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TMO_W-1:0]  timeout_ff;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [ID_W-1:0]   ack_id_ff, ack_id_in;
   logic [IDX_W-1:0]  scan_ff, scan_in;
   logic              held_valid_ff, held_valid_in;
   logic [ID_W-1:0]   held_id_ff, held_id_in;
   logic [CNT_W-1:0]  held_count_ff, held_count_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ACT_W-1:0]  rsp_action_ff, rsp_action_in;
   logic [ID_W-1:0]   rsp_out_id_ff, rsp_out_id_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic              rsp_last_ff, rsp_last_in;

   // Cell chain: cell k holds entry k at rest; during a tick scan the ring
   // rotates toward cell 0, which is the head that gets evaluated.
   entry_type         entries [ID_COUNT];
   cell_cmd_type      cmds [ID_COUNT];
   logic [ID_COUNT-1:0] pend_vec;
   entry_type         head_next;

   logic              accept;
   logic              id_in_range;
   logic [IDX_W-1:0]  cur_idx;
   logic [IDX_W-1:0]  msg_idx;
   logic              do_send, do_ack, do_seen, do_shift;
   logic [TIME_W-1:0] head_age;
   logic              head_due;
   logic [CNT_W-1:0]  count_inc;

   assign accept      = start && !busy;
   assign busy        = (state_ff != ST_IDLE);
   assign csr_ready   = 1'b1;
   assign id_in_range = ({1'b0, req_msg_id} < 7'(ID_COUNT));
   assign cur_idx     = next_id_ff[IDX_W-1:0];
   assign msg_idx     = req_msg_id[IDX_W-1:0];
   assign count_inc   = sat_inc(count_ff);

   // Head cell check: wrapping age against the timeout.
   assign head_age = now_ff - entries[0].stamp;
   assign head_due = entries[0].pending &&
                     ((head_age[TIME_W-1:TMO_W] != '0) || (head_age[TMO_W-1:0] >= timeout_ff));

   always_comb begin
      head_next = entries[0];
      if (head_due) begin
         head_next.stamp = now_ff;
      end
   end

   // Local write strobes are valid only at an accepted request; the shift strobe runs during the scan.
   assign do_send  = accept && (req_mode == MODE_SEND) && !pend_vec[cur_idx];
   assign do_ack   = accept && (req_mode == MODE_ACK) && id_in_range;
   assign do_seen  = accept && (req_mode == MODE_RECV) && id_in_range && !entries[msg_idx].seen;
   assign do_shift = (state_ff == ST_SCAN);

   genvar gi;
   generate
      for (gi = 0; gi < ID_COUNT; gi++) begin : g_cell
         assign pend_vec[gi]      = entries[gi].pending;
         assign cmds[gi].shift    = do_shift;
         assign cmds[gi].set_pend = do_send && (cur_idx == IDX_W'(gi));
         assign cmds[gi].clr_pend = do_ack && (msg_idx == IDX_W'(gi));
         assign cmds[gi].set_seen = do_seen && (msg_idx == IDX_W'(gi));

         if (gi == ID_COUNT - 1) begin : g_tail
            // Close the ring: the head, re-stamped if due, goes to the tail.
            arq_cell u_cell (
               .clock     (clock),
               .reset     (reset),
               .cmd       (cmds[gi]),
               .stamp_in  (req_now_seconds),
               .from_next (head_next),
               .entry_out (entries[gi])
            );
         end else begin : g_body
            arq_cell u_cell (
               .clock     (clock),
               .reset     (reset),
               .cmd       (cmds[gi]),
               .stamp_in  (req_now_seconds),
               .from_next (entries[gi+1]),
               .entry_out (entries[gi])
            );
         end
      end
   endgenerate

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_TICK) begin
                  state_in = ST_SCAN;
               end else if (do_seen) begin
                  state_in = ST_ACK2;
               end
            end
         end
         ST_ACK2: begin
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (scan_ff == IDX_W'(ID_COUNT - 1)) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and result word.
   always_comb begin
      next_id_in    = next_id_ff;
      count_in      = count_ff;
      now_in        = now_ff;
      ack_id_in     = ack_id_ff;
      scan_in       = scan_ff;
      held_valid_in = held_valid_ff;
      held_id_in    = held_id_ff;
      held_count_in = held_count_ff;
      rsp_valid_in  = 1'b0;
      rsp_action_in = rsp_action_ff;
      rsp_out_id_in = rsp_out_id_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_mode)
                  MODE_SEND: begin
                     rsp_valid_in  = 1'b1;
                     rsp_last_in   = 1'b1;
                     rsp_out_id_in = next_id_ff;
                     if (do_send) begin
                        count_in      = count_inc;
                        rsp_action_in = ACT_TX;
                        rsp_count_in  = count_inc;
                        next_id_in    = (cur_idx == IDX_W'(ID_COUNT - 1)) ? '0
                                        : next_id_ff + ID_W'(1);
                     end else begin
                        rsp_action_in = ACT_FULL;
                        rsp_count_in  = count_ff;
                     end
                  end
                  MODE_RECV: begin
                     rsp_valid_in  = 1'b1;
                     rsp_out_id_in = req_msg_id;
                     rsp_count_in  = count_ff;
                     ack_id_in     = req_msg_id;
                     if (do_seen) begin
                        rsp_action_in = ACT_DELIVER;
                     end else begin
                        rsp_action_in = ACT_ACK;
                        rsp_last_in   = 1'b1;
                     end
                  end
                  MODE_TICK: begin
                     now_in        = req_now_seconds;
                     scan_in       = '0;
                     held_valid_in = 1'b0;
                  end
                  default: begin
                     // ack: cell write only, no result
                  end
               endcase
            end
         end
         ST_ACK2: begin
            rsp_valid_in  = 1'b1;
            rsp_last_in   = 1'b1;
            rsp_action_in = ACT_ACK;
            rsp_out_id_in = ack_id_ff;
            rsp_count_in  = count_ff;
         end
         ST_SCAN: begin
            scan_in = scan_ff + IDX_W'(1);
            if (head_due) begin
               // Release the previous retransmit; the new one waits to learn if it is last.
               if (held_valid_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_action_in = ACT_RETX;
                  rsp_out_id_in = held_id_ff;
                  rsp_count_in  = held_count_ff;
               end
               count_in      = count_inc;
               held_valid_in = 1'b1;
               held_id_in    = ID_W'(scan_ff);
               held_count_in = count_inc;
            end
         end
         ST_FLUSH: begin
            if (held_valid_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_last_in   = 1'b1;
               rsp_action_in = ACT_RETX;
               rsp_out_id_in = held_id_ff;
               rsp_count_in  = held_count_ff;
            end
            held_valid_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         next_id_ff    <= '0;
         count_ff      <= '0;
         timeout_ff    <= TIMEOUT_RESET;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_last_ff   <= 1'b0;
         scan_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         next_id_ff    <= next_id_in;
         count_ff      <= count_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_last_ff   <= rsp_last_in;
         scan_ff       <= scan_in;
         if (csr_valid && csr_ready) begin
            timeout_ff <= csr_timeout_seconds;
         end
      end
      now_ff        <= now_in;
      ack_id_ff     <= ack_id_in;
      held_id_ff    <= held_id_in;
      held_count_ff <= held_count_in;
      rsp_action_ff <= rsp_action_in;
      rsp_out_id_ff <= rsp_out_id_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_action        = rsp_action_ff;
   assign rsp_out_id        = rsp_out_id_ff;
   assign rsp_transmissions = rsp_count_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

// ===== design/arq_checker.sv =====
`timescale 1ns / 1ps

module arq_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic [1:0]                  req_mode,
   input  logic                        rsp_valid,
   input  logic [arq_pkg::ACT_W-1:0]   rsp_action,
   input  logic                        rsp_last
);
   import arq_pkg::*;

   // A send answers next cycle with one final word, transmit or refusal.
   a_send_reply: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_mode == MODE_SEND) |=>
         (rsp_valid && rsp_last && (rsp_action == ACT_TX || rsp_action == ACT_FULL)))
      else $error("send did not answer with a final transmit or refusal");

   // An ack yields nothing.
   a_ack_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_mode == MODE_ACK) |=> !rsp_valid)
      else $error("ack produced a result");

   // An app message answers with deliver or ack.
   a_recv_reply: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_mode == MODE_RECV) |=>
         (rsp_valid && (rsp_action == ACT_ACK || rsp_action == ACT_DELIVER)))
      else $error("app message answer missing");

   // A deliver is always followed by the final ack.
   a_deliver_then_ack: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_action == ACT_DELIVER) |=>
         (rsp_valid && rsp_action == ACT_ACK && rsp_last))
      else $error("deliver not followed by ack");

   // The block stays busy between a deliver and its ack.
   a_deliver_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_action == ACT_DELIVER) |-> busy)
      else $error("accepting while ack still owed");

endmodule

bind arq_retransmit_tracker arq_checker u_arq_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_mode   (req_mode),
   .rsp_valid  (rsp_valid),
   .rsp_action (rsp_action),
   .rsp_last   (rsp_last)
);
